/* hdl/rtt_pkg.sv */
// shared constants, codes and control structs for the refcounted timer table
package rtt_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = 5;
    localparam int OP_W    = 3;
    localparam int ST_W    = 3;
    localparam int MS_W    = 32;
    localparam int TAG_W   = 32;
    localparam int NOW_W   = 63;
    localparam int EXP_W   = 64;
    localparam int SCALE_W = 20;
    localparam int PROD_W  = MS_W + SCALE_W;

    localparam logic [SCALE_W-1:0] MS_TO_NS  = SCALE_W'(1000000);
    localparam logic [SLOT_W-1:0]  LAST_IDX  = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]    SLOTS_EXT = (SLOT_W + 1)'(SLOTS);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD_ONESHOT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_HELD    = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL      = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE  = 3'd0;
    localparam logic [ST_W-1:0] ST_ADDED = 3'd1;
    localparam logic [ST_W-1:0] ST_FIRED = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
    localparam logic [ST_W-1:0] ST_BADH  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              clear_all;
        logic              mul;
        logic              add_commit;
        logic              drop_commit;
        logic              slot_commit;
        logic              done_emit;
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] scan_idx;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic slot_fires;
    } dp_status_t;

endpackage

/* hdl/rtt_if.sv */
// valid/ready channel interfaces for request and response words
interface rtt_cmd_if;
    import rtt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [MS_W-1:0]   delay_ms;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] handle;
    logic [NOW_W-1:0]  now_ns;

    modport source (output valid, op, delay_ms, tag, handle, now_ns, input ready);
    modport sink   (input valid, op, delay_ms, tag, handle, now_ns, output ready);
endinterface

interface rtt_rsp_if;
    import rtt_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  fired_tag;
    logic              last;

    modport source (output valid, status, slot, fired_tag, last, input ready);
    modport sink   (input valid, status, slot, fired_tag, last, output ready);
endinterface

/* hdl/rtt_ctrl.sv */
// sequencing state machine for adds, drops, tick scans and clears
module rtt_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [rtt_pkg::OP_W-1:0] in_op,
    output logic                   in_ready,
    input  rtt_pkg::dp_status_t    stat,
    output rtt_pkg::ctl_cmd_t      cmd
);
    import rtt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_MUL        = 7'b0000010,
        S_ADD        = 7'b0000100,
        S_DROP       = 7'b0001000,
        S_SCAN_START = 7'b0010000,
        S_SCAN       = 7'b0100000,
        S_FINISH     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    // state and scan index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.scan_idx = idx_reg;
        cmd.rd_addr  = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    case (in_op)
                        OP_ADD_ONESHOT, OP_ADD_HELD: state_next = S_MUL;
                        OP_RELEASE, OP_CANCEL:       state_next = S_DROP;
                        OP_TICK:                     state_next = S_SCAN_START;
                        OP_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                            state_next    = S_FINISH;
                        end
                        default:                     state_next = S_FINISH;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.add_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DROP:
            begin
                if (stat.out_free)
                begin
                    cmd.drop_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN_START:
            begin
                cmd.rd_addr = '0;
                idx_next    = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                // a firing slot waits for room in the output register
                if (!stat.slot_fires || stat.out_free)
                begin
                    cmd.slot_commit = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 1'b1;
                        cmd.rd_addr = idx_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.done_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/rtt_dp.sv */
// slot table storage, expiry arithmetic and result register
module rtt_dp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rtt_pkg::ctl_cmd_t          cmd,
    output rtt_pkg::dp_status_t        stat,
    input  logic [rtt_pkg::OP_W-1:0]   in_op,
    input  logic [rtt_pkg::MS_W-1:0]   in_delay_ms,
    input  logic [rtt_pkg::TAG_W-1:0]  in_tag,
    input  logic [rtt_pkg::SLOT_W-1:0] in_handle,
    input  logic [rtt_pkg::NOW_W-1:0]  in_now_ns,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rtt_pkg::ST_W-1:0]   out_status,
    output logic [rtt_pkg::SLOT_W-1:0] out_slot,
    output logic [rtt_pkg::TAG_W-1:0]  out_fired_tag,
    output logic                       out_last
);
    import rtt_pkg::*;

    logic [OP_W-1:0]   op_reg;
    logic [MS_W-1:0]   delay_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] handle_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  cancelled_reg;
    logic [SLOTS-1:0]  held_reg;

    logic [EXP_W-1:0]  exp_mem [SLOTS];
    logic [TAG_W-1:0]  tag_mem [SLOTS];
    logic [EXP_W-1:0]  exp_q_reg;
    logic [TAG_W-1:0]  tag_q_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TAG_W-1:0]  fired_tag_reg;
    logic              last_reg;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              bad_handle;
    logic              fires;
    logic              cancel_eff;
    logic [EXP_W-1:0]  expiry_sum;
    logic              emit;
    logic              out_free;

    // request word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= in_op;
            delay_reg  <= in_delay_ms;
            tag_reg    <= in_tag;
            handle_reg <= in_handle;
            now_reg    <= in_now_ns;
        end
    end

    // delay scaled to nanoseconds, registered before the add
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(delay_reg) * PROD_W'(MS_TO_NS);
        end
    end

    assign expiry_sum = {1'b0, now_reg} + EXP_W'(prod_reg);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign bad_handle = ({1'b0, handle_reg} >= SLOTS_EXT) || !used_reg[handle_reg];

    // fire test for the slot under scan
    assign fires = used_reg[cmd.scan_idx] && !cancelled_reg[cmd.scan_idx]
                   && (exp_q_reg < {1'b0, now_reg});
    assign cancel_eff = cancelled_reg[cmd.scan_idx] || fires;

    // expiry and tag memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.add_commit && free_found)
        begin
            exp_mem[free_idx] <= expiry_sum;
            tag_mem[free_idx] <= tag_reg;
        end
        exp_q_reg <= exp_mem[cmd.rd_addr];
        tag_q_reg <= tag_mem[cmd.rd_addr];
    end

    // in-use map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            used_reg <= '0;
        end
        else if (cmd.add_commit && free_found)
        begin
            used_reg[free_idx] <= 1'b1;
        end
        else if (cmd.slot_commit && used_reg[cmd.scan_idx] && cancel_eff
                 && !held_reg[cmd.scan_idx])
        begin
            used_reg[cmd.scan_idx] <= 1'b0;
        end
    end

    // cancelled and reference flags
    always_ff @(posedge clk)
    begin
        if (cmd.add_commit && free_found)
        begin
            cancelled_reg[free_idx] <= 1'b0;
            held_reg[free_idx]      <= (op_reg == OP_ADD_HELD);
        end
        else if (cmd.drop_commit && !bad_handle)
        begin
            held_reg[handle_reg] <= 1'b0;
            if (op_reg == OP_CANCEL)
            begin
                cancelled_reg[handle_reg] <= 1'b1;
            end
        end
        else if (cmd.slot_commit && fires)
        begin
            cancelled_reg[cmd.scan_idx] <= 1'b1;
        end
    end

    assign emit = cmd.add_commit || cmd.drop_commit || cmd.done_emit
                  || (cmd.slot_commit && fires);

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg    <= ST_DONE;
            slot_reg      <= '0;
            fired_tag_reg <= '0;
            last_reg      <= 1'b1;
            if (cmd.add_commit)
            begin
                status_reg <= free_found ? ST_ADDED : ST_FULL;
                slot_reg   <= free_found ? free_idx : '0;
            end
            else if (cmd.drop_commit)
            begin
                if (bad_handle)
                begin
                    status_reg <= ST_BADH;
                    slot_reg   <= handle_reg;
                end
            end
            else if (cmd.slot_commit)
            begin
                status_reg    <= ST_FIRED;
                slot_reg      <= cmd.scan_idx;
                fired_tag_reg <= tag_q_reg;
                last_reg      <= 1'b0;
            end
        end
    end

    assign out_free        = !out_valid_reg || out_ready;
    assign stat.out_free   = out_free;
    assign stat.slot_fires = fires;

    assign out_valid     = out_valid_reg;
    assign out_status    = status_reg;
    assign out_slot      = slot_reg;
    assign out_fired_tag = fired_tag_reg;
    assign out_last      = last_reg;

endmodule

/* hdl/refcounted_timer_table_core.sv */
// Refcounted timer table, top level. Holds 32 timer slots. An add steps through
// capture, scale of the delay to nanoseconds in a registered multiplier, then
// the 64-bit add and table write, and picks the lowest free slot. Release and
// cancel go from capture to the drop; clear and unknown ops go to the done word.
// A tick walks all 32 slots through the expiry/tag memory, one slot per cycle
// unless a firing slot waits for output room, with the next read issued ahead.
// Every step that writes a word waits while the output register holds a word
// not yet taken. Each request answers with one word, or for a tick with one
// fired word per expiring slot followed by a done word; last marks the final
// word. A new request is taken once the previous one has handed its final word
// to the output register. The in-use map clears at reset with no sweep.
module refcounted_timer_table_core
(
    input  logic      clk,
    input  logic      rst_n,
    rtt_cmd_if.sink   cmd,
    rtt_rsp_if.source rsp
);
    import rtt_pkg::*;

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_stat;

    // control sequencer
    rtt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_op    (cmd.op),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    // slot table and result path
    rtt_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctl_cmd),
        .stat          (dp_stat),
        .in_op         (cmd.op),
        .in_delay_ms   (cmd.delay_ms),
        .in_tag        (cmd.tag),
        .in_handle     (cmd.handle),
        .in_now_ns     (cmd.now_ns),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_slot      (rsp.slot),
        .out_fired_tag (rsp.fired_tag),
        .out_last      (rsp.last)
    );

endmodule

/* hdl/rtt_checker.sv */
// port-level checks for the timer table, bound to the top level
module rtt_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [rtt_pkg::ST_W-1:0]   rsp_status,
    input logic [rtt_pkg::SLOT_W-1:0] rsp_slot,
    input logic [rtt_pkg::TAG_W-1:0]  rsp_fired_tag,
    input logic                       rsp_last
);
    import rtt_pkg::*;

    // a taken request leaves the block busy on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request taken while previous one still in progress");

    // fired words are never final, every other word is
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_status == ST_FIRED) != rsp_last))
        else $error("last flag does not match word kind");

    // only fired words carry a tag
    a_tag_only_fired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_FIRED) |-> (rsp_fired_tag == '0))
        else $error("tag on a word that did not fire");

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot) && $stable(rsp_fired_tag) && $stable(rsp_last))
        else $error("response word changed while stalled");

endmodule

bind refcounted_timer_table_core rtt_checker u_rtt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_slot      (rsp.slot),
    .rsp_fired_tag (rsp.fired_tag),
    .rsp_last      (rsp.last)
);
